>>> hw/rtl/assert_macros.svh
// assertion macros used by the slot allocator core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/sas_pkg.sv
// shared types, constants and helpers of the slot allocator
`default_nettype none

package sas_pkg;

   localparam int SLOT_COUNT = 16;
   localparam int HANDLE_W   = 4;
   localparam int TAG_W      = $clog2(SLOT_COUNT + 1);
   localparam int ADDR_W     = $clog2(SLOT_COUNT);

   localparam logic [TAG_W-1:0] TAG_FREE = '0;
   localparam logic [TAG_W-1:0] TAG_LONE = TAG_W'(SLOT_COUNT);

   localparam logic [2:0] OP_ALLOC = 3'd0;
   localparam logic [2:0] OP_FREE  = 3'd1;
   localparam logic [2:0] OP_ADD   = 3'd2;
   localparam logic [2:0] OP_FIND  = 3'd3;
   localparam logic [2:0] OP_DROP  = 3'd4;

   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_FULL       = 3'd1;
   localparam logic [2:0] ST_BAD_HANDLE = 3'd2;
   localparam logic [2:0] ST_NOT_SET    = 3'd3;
   localparam logic [2:0] ST_OTHER_SET  = 3'd4;
   localparam logic [2:0] ST_ELEM_FREE  = 3'd5;

   typedef struct packed {
      logic [2:0]          opcode;
      logic [HANDLE_W-1:0] set_handle;
      logic [HANDLE_W-1:0] element_handle;
   } req_type;

   typedef struct packed {
      logic [HANDLE_W-1:0] result_handle;
      logic                found;
      logic [2:0]          status;
   } rsp_type;

   typedef struct packed {
      logic load;     // capture the incoming item
      logic rd_en;    // register both table read ports
      logic scan;     // port a follows the scan counter
      logic commit;   // write the table and load the result
   } cmd_type;

   typedef struct packed {
      logic hit;      // scanned slot is free
      logic done;     // scan found a slot or ran out
   } stat_type;

   function automatic logic handle_ok(input logic [HANDLE_W-1:0] h);
      return (h != '0) && (TAG_W'(h) < TAG_W'(SLOT_COUNT));
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/sas_ctrl.sv
// controller state machine of the slot allocator
`default_nettype none

module sas_ctrl import sas_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic [2:0] req_opcode,
   output logic            req_stall,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   input  wire stat_type   stat,
   output cmd_type         cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_LOOK,
      S_EXEC
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;
   logic      accept;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      cmd.load = accept;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = (req_opcode == OP_ALLOC) ? S_SCAN : S_LOOK;
            end
         end
         S_SCAN: begin
            cmd.scan  = 1'b1;
            // hold the read data once a free slot shows up
            cmd.rd_en = !stat.hit;
            if (stat.done && out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         S_LOOK: begin
            cmd.rd_en = 1'b1;
            state_in  = S_EXEC;
         end
         S_EXEC: begin
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/sas_dpath.sv
// datapath of the slot allocator: tag table, read ports, scan counter, result
`default_nettype none

module sas_dpath import sas_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cmd_type cmd,
   input  wire req_type req_data,
   output stat_type     stat,
   output rsp_type      rsp_data
);

   logic [TAG_W-1:0]      tag_mem [SLOT_COUNT];
   logic [SLOT_COUNT-1:0] tag_vld_ff;

   req_type          req_ff;
   rsp_type          rsp_ff, rsp_in;
   logic [TAG_W-1:0] rda_ff, rdb_ff;
   logic [ADDR_W-1:0] rda_addr_ff;
   logic [TAG_W-1:0] scan_idx_ff;
   logic             scan_vld_ff;

   logic [ADDR_W-1:0] addr_a, addr_b;
   logic              scan_more;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [TAG_W-1:0]  wr_data;
   logic              s_ok, e_ok;
   logic [TAG_W-1:0]  s_tag;
   logic [2:0]        pair_st;

   assign addr_a    = cmd.scan ? scan_idx_ff[ADDR_W-1:0] : req_ff.set_handle[ADDR_W-1:0];
   assign addr_b    = req_ff.element_handle[ADDR_W-1:0];
   assign scan_more = (scan_idx_ff < TAG_W'(SLOT_COUNT));

   assign stat.hit  = scan_vld_ff && (rda_ff == TAG_FREE);
   assign stat.done = stat.hit || (!scan_more && !scan_vld_ff);

   assign s_ok  = handle_ok(req_ff.set_handle);
   assign e_ok  = handle_ok(req_ff.element_handle);
   assign s_tag = TAG_W'(req_ff.set_handle);

   // shared checks of add, find and drop, in their fixed order
   always_comb begin
      if (!s_ok) begin
         pair_st = ST_BAD_HANDLE;
      end else if (rda_ff != TAG_LONE) begin
         pair_st = ST_NOT_SET;
      end else if (!e_ok) begin
         pair_st = ST_BAD_HANDLE;
      end else if (rdb_ff == TAG_FREE) begin
         pair_st = ST_ELEM_FREE;
      end else begin
         pair_st = ST_OK;
      end
   end

   always_comb begin
      rsp_in  = '0;
      wr_en   = 1'b0;
      wr_addr = addr_b;
      wr_data = TAG_LONE;
      case (req_ff.opcode)
         OP_ALLOC: begin
            if (stat.hit) begin
               wr_en                = 1'b1;
               wr_addr              = rda_addr_ff;
               rsp_in.result_handle = HANDLE_W'(rda_addr_ff);
            end else begin
               rsp_in.status = ST_FULL;
            end
         end
         OP_FREE: begin
            if (req_ff.set_handle != '0) begin
               if (s_ok) begin
                  wr_en   = 1'b1;
                  wr_addr = req_ff.set_handle[ADDR_W-1:0];
                  wr_data = TAG_FREE;
               end else begin
                  rsp_in.status = ST_BAD_HANDLE;
               end
            end
         end
         OP_ADD: begin
            rsp_in.status = pair_st;
            if (pair_st == ST_OK) begin
               if (rdb_ff == TAG_LONE) begin
                  wr_en                = 1'b1;
                  wr_data              = s_tag;
                  rsp_in.result_handle = req_ff.element_handle;
               end else if (rdb_ff == s_tag) begin
                  rsp_in.result_handle = req_ff.element_handle;
               end else begin
                  rsp_in.status = ST_OTHER_SET;
               end
            end
         end
         OP_FIND, OP_DROP: begin
            rsp_in.status = pair_st;
            if ((pair_st == ST_OK) && (rdb_ff == s_tag)) begin
               rsp_in.found         = 1'b1;
               rsp_in.result_handle = req_ff.element_handle;
               wr_en                = (req_ff.opcode == OP_DROP);
            end
         end
         default: begin
            rsp_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
      if (cmd.rd_en) begin
         rda_ff      <= tag_vld_ff[addr_a] ? tag_mem[addr_a] : TAG_FREE;
         rdb_ff      <= tag_vld_ff[addr_b] ? tag_mem[addr_b] : TAG_FREE;
         rda_addr_ff <= addr_a;
      end
      if (cmd.commit && wr_en) begin
         tag_mem[wr_addr] <= wr_data;
      end
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   // never-written slots read as free
   always_ff @(posedge clock) begin
      if (reset) begin
         tag_vld_ff  <= '0;
         scan_idx_ff <= '0;
         scan_vld_ff <= 1'b0;
      end else begin
         if (cmd.commit && wr_en) begin
            tag_vld_ff[wr_addr] <= 1'b1;
         end
         if (cmd.load) begin
            scan_idx_ff <= TAG_W'(1);
            scan_vld_ff <= 1'b0;
         end else if (cmd.rd_en && cmd.scan) begin
            scan_vld_ff <= scan_more;
            if (scan_more) begin
               scan_idx_ff <= scan_idx_ff + TAG_W'(1);
            end
         end else if (cmd.rd_en) begin
            scan_vld_ff <= 1'b0;
         end
      end
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

>>> hw/rtl/slot_allocator_with_set_membership_core.sv
// allocate: scans the tag table one slot per cycle
// through the registered read port of the tag table
// free, add, find, drop and unknown codes: the look state registers both read ports, then exec gives the result
// one item at a time; a finished result waits in the output register
// reset clears the slot valid bits, so every slot reads as free
`default_nettype none

`include "assert_macros.svh"

module slot_allocator_with_set_membership_core import sas_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   cmd_type  cmd;
   stat_type stat;
   logic     rsp_err;
   logic     rsp_clean;

   sas_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_data.opcode),
      .req_stall  (req_stall),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .stat       (stat),
      .cmd        (cmd)
   );

   sas_dpath u_dpath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

   assign rsp_err   = rsp_valid && (rsp_data.status != ST_OK);
   assign rsp_clean = (rsp_data.result_handle == '0) && !rsp_data.found;

   `ASSERT_SAME(a_commit_room, cmd.commit, !rsp_valid || !rsp_stall, "commit with output full")
   `ASSERT_NEXT(a_commit_shows, cmd.commit, rsp_valid, "committed item not presented")
   `ASSERT_SAME(a_err_zero, rsp_err, rsp_clean, "error item carries a handle")
   `ASSERT_SAME(a_load_idle, cmd.load, !cmd.rd_en && !cmd.commit, "item taken while busy")

endmodule

`default_nettype wire
